// ----- sv/sbng_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the Stradella bass note generator.
// No dependencies; every other file refers to this package by scoped names.
package sbng_pkg;

  localparam int NUM_TRACKS_DEFAULT = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int SLOTS              = 10;  // five chord positions, each with an octave copy
  localparam int POSITIONS          = 5;

  localparam logic [2:0] ROW_BASS    = 3'd1;
  localparam logic [6:0] NOTE_MAX    = 7'd127;
  localparam logic [6:0] OCTAVE      = 7'd12;
  localparam logic [7:0] PERCENT_MAX = 8'd150;
  localparam logic [1:0] DENS_SPARSE = 2'd0;
  localparam logic [1:0] DENS_NORMAL = 2'd1;
  localparam logic [1:0] DENS_DENSE  = 2'd2;

  // config register indexes
  localparam logic [2:0] REG_BASE_NOTE  = 3'd0;
  localparam logic [2:0] REG_OCT_DOUBLE = 3'd1;
  localparam logic [2:0] REG_DENSITY    = 3'd2;
  localparam logic [2:0] REG_BASS_PCT   = 3'd3;
  localparam logic [2:0] REG_CHORD_PCT  = 3'd4;

  typedef struct packed {
    logic [6:0] floor_note;
    logic       oct_copy;
    logic [1:0] density;
    logic [7:0] bass_pct;
    logic [7:0] chord_pct;
  } cfg_t;

  // one press after classification: slot 2k is chord position k, slot 2k+1 its copy
  typedef struct packed {
    logic [7:0]             track;
    logic [3:0]             channel;
    logic [6:0]             velocity;
    logic [SLOTS-1:0]       mask;
    logic [SLOTS-1:0][6:0]  notes;
  } desc_t;

  // circle of fifths, semitones above the bass range floor
  function automatic logic [3:0] fifths(input logic [3:0] col);
    logic [3:0] r;
    case (col)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd7;
      4'd2:    r = 4'd2;
      4'd3:    r = 4'd9;
      4'd4:    r = 4'd4;
      4'd5:    r = 4'd11;
      4'd6:    r = 4'd6;
      4'd7:    r = 4'd1;
      4'd8:    r = 4'd8;
      4'd9:    r = 4'd3;
      4'd10:   r = 4'd10;
      4'd11:   r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // interval of chord position pos for row kind row
  function automatic logic [3:0] row_interval(input logic [2:0] row, input logic [2:0] pos);
    logic [3:0] r;
    r = 4'd0;
    case (row)
      3'd0: if (pos == 3'd1) r = 4'd7;
      3'd1: if (pos == 3'd1) r = 4'd12;
      3'd2: case (pos)
              3'd1:    r = 4'd4;
              3'd2:    r = 4'd7;
              3'd3:    r = 4'd12;
              default: r = 4'd0;
            endcase
      3'd3: case (pos)
              3'd1:    r = 4'd3;
              3'd2:    r = 4'd7;
              3'd3:    r = 4'd12;
              default: r = 4'd0;
            endcase
      3'd4: case (pos)
              3'd1:    r = 4'd4;
              3'd2:    r = 4'd7;
              3'd3:    r = 4'd10;
              3'd4:    r = 4'd12;
              default: r = 4'd0;
            endcase
      3'd5: case (pos)
              3'd1:    r = 4'd3;
              3'd2:    r = 4'd6;
              3'd3:    r = 4'd9;
              3'd4:    r = 4'd12;
              default: r = 4'd0;
            endcase
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] row_count(input logic [2:0] row);
    logic [2:0] r;
    if (row < 3'd2)      r = 3'd2;
    else if (row < 3'd4) r = 3'd4;
    else                 r = 3'd5;
    return r;
  endfunction

endpackage

// ----- sv/sbng_front.sv -----
`timescale 1ns / 1ps
// Front end: takes button presses, splits row and column, scales velocity and
// builds the note slot list. Depends on sbng_pkg.
module sbng_front #(
  parameter int NUM_TRACKS = sbng_pkg::NUM_TRACKS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  sbng_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_track,
  input  logic [7:0]         in_button,
  input  logic [6:0]         in_velocity,
  input  logic [3:0]         in_channel,
  output logic               push_valid,
  input  logic               push_ready,
  output sbng_pkg::desc_t    push_data
);

  // stage A registers
  logic        a_valid;
  logic [7:0]  a_track;
  logic [3:0]  a_channel;
  logic [2:0]  a_row;
  logic [7:0]  a_bottom;
  logic [14:0] a_prod;

  logic        in_fire;
  logic        track_ok;
  logic        btn_bass;
  logic [15:0] row_mul;
  logic [3:0]  row_full;
  logic [7:0]  row_x20;
  logic [7:0]  col;
  logic [3:0]  col12;
  logic [2:0]  row_code;
  logic [7:0]  pct;

  assign track_ok = {1'b0, in_track} < 9'(NUM_TRACKS);
  // rows 0, 1 and 6 and up all play as bass rows
  assign btn_bass = (in_button < 8'd40) || (in_button >= 8'd120);
  assign pct      = btn_bass ? cfg.bass_pct : cfg.chord_pct;

  always_comb begin
    row_mul  = 16'(in_button) * 16'd205;   // floor(b/20) == (b*205)>>12 for b < 256
    row_full = row_mul[15:12];
    row_x20  = {row_full, 4'b0} + {2'b0, row_full, 2'b0};
    col      = in_button - row_x20;
    col12    = (col[4:0] >= 5'd12) ? 4'(col[4:0] - 5'd12) : col[3:0];
    row_code = (row_full >= 4'd6) ? sbng_pkg::ROW_BASS : row_full[2:0];
  end

  // stage B
  logic        keep;
  logic [27:0] q_mul;
  logic [8:0]  quot;
  logic [6:0]  vel_sat;
  logic [2:0]  count;
  logic        bass_row;
  logic [3:0]  iv   [sbng_pkg::POSITIONS];
  logic [8:0]  sum  [sbng_pkg::POSITIONS];
  logic [sbng_pkg::SLOTS-1:0] mask;
  logic [sbng_pkg::SLOTS-1:0][6:0] notes;

  always_comb begin
    q_mul    = 28'(a_prod) * 28'd5243;  // /100, exact for products below 19051
    quot     = q_mul[27:19];
    vel_sat  = (quot > 9'(sbng_pkg::NOTE_MAX)) ? sbng_pkg::NOTE_MAX : quot[6:0];
    bass_row = a_row <= sbng_pkg::ROW_BASS;
    count    = sbng_pkg::row_count(a_row);
    if (cfg.density == sbng_pkg::DENS_SPARSE && count > 3'd3) begin
      count = 3'd3;
    end else if (cfg.density == sbng_pkg::DENS_DENSE) begin
      count = 3'd5;
    end
    for (int i = 0; i < sbng_pkg::POSITIONS; i++) begin
      iv[i]  = sbng_pkg::row_interval(a_row, 3'(i));
      sum[i] = {1'b0, a_bottom} + 9'(iv[i]);
      mask[2*i]    = (3'(i) < count) && (i == 0 || iv[i] != 4'd0) &&
                     (sum[i] <= 9'(sbng_pkg::NOTE_MAX));
      notes[2*i]   = sum[i][6:0];
      mask[2*i+1]  = mask[2*i] && cfg.oct_copy && bass_row &&
                     (sum[i][6:0] >= sbng_pkg::OCTAVE);
      notes[2*i+1] = sum[i][6:0] - sbng_pkg::OCTAVE;
    end
    keep = |mask;
  end

  assign push_valid        = a_valid && keep;
  assign push_data.track    = a_track;
  assign push_data.channel  = a_channel;
  assign push_data.velocity = vel_sat;
  assign push_data.mask     = mask;
  assign push_data.notes    = notes;

  // a press that sounds nothing leaves stage A without a push
  assign in_ready = !a_valid || !keep || push_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_fire && track_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_track   <= in_track;
      a_channel <= in_channel;
      a_row     <= row_code;
      a_bottom  <= {1'b0, cfg.floor_note} + {4'b0, sbng_pkg::fifths(col12)};
      a_prod    <= 15'(in_velocity) * 15'(pct);
    end
  end

endmodule

// ----- sv/sbng_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of classified presses between front and back end.
// Depends on sbng_pkg for desc_t and the depth.
module sbng_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sbng_pkg::desc_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sbng_pkg::desc_t pop_data
);

  localparam int DEPTH = sbng_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  sbng_pkg::desc_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = fill != CW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      fill <= fill + CW'(1);
      else if (do_pop && !do_push) fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/sbng_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the slot mask of one press and emits one note word a cycle
// while m_tready is high, through an output register. Depends on sbng_pkg.
module sbng_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sbng_pkg::desc_t pop_data,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata,
  output logic            m_tlast
);

  sbng_pkg::desc_t            cur;
  logic                       busy;
  logic [sbng_pkg::SLOTS-1:0] rem;

  logic                       out_load;
  logic [sbng_pkg::SLOTS-1:0] pick;
  logic [sbng_pkg::SLOTS-1:0] rest;
  logic                       last;
  logic [6:0]                 note_sel;

  always_comb begin
    pick     = rem & (-rem);  // lowest pending slot
    rest     = rem & ~pick;
    last     = rest == '0;
    note_sel = '0;
    for (int i = 0; i < sbng_pkg::SLOTS; i++) begin
      note_sel = note_sel | (cur.notes[i] & {7{pick[i]}});
    end
  end

  assign out_load  = busy && (!m_tvalid || m_tready);
  assign pop_ready = !busy || (out_load && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
      end else if (out_load && last) begin
        busy <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
      rem <= pop_data.mask;
    end else if (out_load) begin
      rem <= rest;
    end
    if (out_load) begin
      m_tdata <= {6'b0, cur.channel, cur.velocity, note_sel, cur.track};
      m_tlast <= last;
    end
  end

endmodule

// ----- sv/stradella_bass_note_generator.sv -----
`timescale 1ns / 1ps
// Stradella bass note generator, top level. Holds the config registers and
// ties front end, queue and back end together. Depends on sbng_pkg, sbng_front, sbng_queue and sbng_back.
//
// Usage:
//  - s_* takes one button press per word; m_* gives one note per word, tlast on
//    the final note of a press. cfg_* writes register cfg_index with cfg_data;
//    cfg_ready is always high. Write config only while the block is idle.
//  - Path: after stage A a press passes the queue write, the back end load and
//    the output register.
//  - Throughput: the back end emits one note a cycle while m_tready is high, so a
//    press giving n notes (1..5) gives n words; the front end and the two-word queue
//    keep taking presses meanwhile. Presses with an out-of-range track or no
//    playable note give no words and never reach the queue.
//  - Reset (rst, synchronous) empties every stage and loads the register
//    defaults: base 36, doubling on, normal voicing, 110% bass, 90% chord.
//  - When m_tready is low the current note holds; the queue fills, then
//    s_tready drops until the back end drains.
module stradella_bass_note_generator #(
  parameter int NUM_TRACKS = sbng_pkg::NUM_TRACKS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [7:0] track_id, [15:8] button, [22:16] key_velocity,
                                  // [26:23] midi_channel, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [7:0] out_track, [14:8] note_number,
                                  // [21:15] note_velocity, [25:22] out_channel, rest zero
  output logic        m_tlast,    // last_note
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  sbng_pkg::cfg_t  cfg;
  sbng_pkg::desc_t push_data;
  sbng_pkg::desc_t pop_data;
  logic            push_valid;
  logic            push_ready;
  logic            pop_valid;
  logic            pop_ready;

  assign cfg_ready = 1'b1;

  // register writes; out-of-range density and percent values clamp, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_note <= 7'd36;
      cfg.oct_copy   <= 1'b1;
      cfg.density    <= sbng_pkg::DENS_NORMAL;
      cfg.bass_pct   <= 8'd110;
      cfg.chord_pct  <= 8'd90;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbng_pkg::REG_BASE_NOTE:  cfg.floor_note <= cfg_data[6:0];
        sbng_pkg::REG_OCT_DOUBLE: cfg.oct_copy   <= cfg_data[0];
        sbng_pkg::REG_DENSITY:
          cfg.density <= (cfg_data[1:0] > sbng_pkg::DENS_DENSE) ?
                         sbng_pkg::DENS_DENSE : cfg_data[1:0];
        sbng_pkg::REG_BASS_PCT:
          cfg.bass_pct  <= (cfg_data > sbng_pkg::PERCENT_MAX) ? sbng_pkg::PERCENT_MAX : cfg_data;
        sbng_pkg::REG_CHORD_PCT:
          cfg.chord_pct <= (cfg_data > sbng_pkg::PERCENT_MAX) ? sbng_pkg::PERCENT_MAX : cfg_data;
        default: ;
      endcase
    end
  end

  sbng_front #(
    .NUM_TRACKS(NUM_TRACKS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_track   (s_tdata[7:0]),
    .in_button  (s_tdata[15:8]),
    .in_velocity(s_tdata[22:16]),
    .in_channel (s_tdata[26:23]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sbng_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  sbng_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- dv/sbng_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the Stradella bass note generator: tracks register writes,
// predicts the notes of every press and compares them with the note words.
// Depends on sbng_pkg for the register indexes, density codes and cfg_t.
module sbng_checker #(
  parameter int NUM_TRACKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] track;
    logic [6:0] note;
    logic [6:0] vel;
    logic [3:0] ch;
    logic       last;
  } note_t;

  note_t          due_notes[$];
  sbng_pkg::cfg_t regs;
  int             mism;

  // chord shape per row, one nibble per position, position 0 lowest
  function automatic logic [23:0] chord_shape(input int row);
    case (row)
      0:       return 24'h000070;  // counter-bass: root, fifth
      1:       return 24'h0000C0;  // bass: root, octave
      2:       return 24'h00C740;  // major
      3:       return 24'h00C730;  // minor
      4:       return 24'h0CA740;  // dominant seventh
      default: return 24'h0C9630;  // diminished seventh
    endcase
  endfunction

  function automatic void voice_press(input logic [7:0] trk, input logic [7:0] btn,
                                      input logic [6:0] kv, input logic [3:0] ch);
    int          row, bottom, pct, vel, count, iv, pitch;
    bit          bass;
    logic [23:0] shape;
    int          pitches[$];
    note_t       w;
    if (trk >= NUM_TRACKS) return;
    row = btn / 20;
    if (row > 5) row = 1;
    // circle of fifths is seven semitones per column step
    bottom = regs.floor_note + (((btn % 20) % 12) * 7) % 12;
    bass = row < 2;
    pct = bass ? regs.bass_pct : regs.chord_pct;
    vel = kv * pct / 100;
    if (vel > 127) vel = 127;
    count = (row < 2) ? 2 : (row < 4) ? 4 : 5;
    if (regs.density == sbng_pkg::DENS_SPARSE && count > 3) count = 3;
    else if (regs.density == sbng_pkg::DENS_DENSE && count < 5) count = 5;
    shape = chord_shape(row);
    for (int i = 0; i < count; i++) begin
      iv = shape[i*4 +: 4];
      if (iv == 0 && i > 0) continue;  // empty table slot
      pitch = bottom + iv;
      if (pitch > 127) continue;
      if (pitches.size() < 5) pitches.push_back(pitch);
      if (regs.oct_copy && bass && pitch >= 12 && pitches.size() < 5)
        pitches.push_back(pitch - 12);
    end
    foreach (pitches[k]) begin
      w.track = trk;
      w.note  = 7'(pitches[k]);
      w.vel   = 7'(vel);
      w.ch    = ch;
      w.last  = (k == pitches.size() - 1);
      due_notes.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    note_t want, got;
    if (rst) begin
      regs.floor_note = 7'd36;
      regs.oct_copy   = 1'b1;
      regs.density    = sbng_pkg::DENS_NORMAL;
      regs.bass_pct   = 8'd110;
      regs.chord_pct  = 8'd90;
      due_notes.delete();
      mism = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[7:0], m_tdata[14:8], m_tdata[21:15], m_tdata[25:22], m_tlast};
        if (due_notes.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("%t unexpected note word %h last %b", $realtime, m_tdata, m_tlast);
        end else begin
          want = due_notes.pop_front();
          if (got !== want || m_tdata[31:26] !== 6'd0) begin
            mism++;
            if (mism <= 10)
              $display({"%t note mismatch (exp/got) trk %0d/%0d note %0d/%0d ",
                        "vel %0d/%0d ch %0d/%0d last %b/%b pad 0/%h"},
                       $realtime, want.track, got.track, want.note, got.note, want.vel,
                       got.vel, want.ch, got.ch, want.last, got.last, m_tdata[31:26]);
          end
        end
      end
      if (s_tvalid && s_tready)
        voice_press(s_tdata[7:0], s_tdata[15:8], s_tdata[22:16], s_tdata[26:23]);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sbng_pkg::REG_BASE_NOTE:  regs.floor_note = cfg_data[6:0];
          sbng_pkg::REG_OCT_DOUBLE: regs.oct_copy   = cfg_data[0];
          sbng_pkg::REG_DENSITY:
            regs.density = (cfg_data[1:0] > sbng_pkg::DENS_DENSE) ? sbng_pkg::DENS_DENSE
                                                                  : cfg_data[1:0];
          sbng_pkg::REG_BASS_PCT:
            regs.bass_pct = (cfg_data > sbng_pkg::PERCENT_MAX) ? sbng_pkg::PERCENT_MAX
                                                               : cfg_data;
          sbng_pkg::REG_CHORD_PCT:
            regs.chord_pct = (cfg_data > sbng_pkg::PERCENT_MAX) ? sbng_pkg::PERCENT_MAX
                                                                : cfg_data;
          default: ;
        endcase
      end
    end
    errors  <= mism;
    pending <= due_notes.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the Stradella bass note generator: clock, reset, press and
// register stimulus, note sink and verdict. Depends on sbng_pkg, sbng_checker and the RTL.
module tb_top;

  localparam int TRACKS      = 16;
  localparam int HOLD_CYCLES = 80;    // long sink hold-off, fills queue and stalls s_tready
  localparam int DRAIN       = 16;    // covers the pipe for presses with no notes
  localparam int STUCK_LIMIT = 2000;  // cycles without any accepted word

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [7:0] track_id, [15:8] button, [22:16] key_velocity,
                          // [26:23] midi_channel, rest zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [7:0] out_track, [14:8] note_number,
                          // [21:15] note_velocity, [25:22] out_channel, rest zero
  logic        m_tlast;   // last_note
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  int errors;
  int pending;
  int hold_reqs;      // bumped by stimulus, served by the sink
  int idle_gap = 0;   // cycles since any word was accepted
  bit idle_on;        // random gaps and stalls on both sides

  stradella_bass_note_generator #(.NUM_TRACKS(TRACKS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sbng_checker #(.NUM_TRACKS(TRACKS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  // Watchdog: a run that stops moving words is a failure.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_gap <= 0;
    else
      idle_gap <= idle_gap + 1;
    if (idle_gap >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Note sink. Serves one long hold-off per request, otherwise short random stalls while idle_on is set.
  initial begin : sink
    int holds_done;
    holds_done = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end : sink

  // One press word; valid stays up afterwards unless a random gap follows.
  task automatic send_press(input logic [7:0] trk, input logic [7:0] btn,
                            input logic [6:0] kv, input logic [3:0] ch);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, ch, kv, btn, trk};
    do @(posedge clk); while (!s_tready);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop offering presses, wait for every due note, then let the pipe empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register set plus one write past the map, which must be dropped.
  task automatic program_regs(input logic [7:0] base, input logic [7:0] dbl,
                              input logic [7:0] dens, input logic [7:0] bass,
                              input logic [7:0] chord);
    put_reg(sbng_pkg::REG_BASE_NOTE, base);
    put_reg(sbng_pkg::REG_OCT_DOUBLE, dbl);
    put_reg(sbng_pkg::REG_DENSITY, dens);
    put_reg(sbng_pkg::REG_BASS_PCT, bass);
    put_reg(sbng_pkg::REG_CHORD_PCT, chord);
    put_reg(sbng_pkg::REG_CHORD_PCT + 3'd1 + 3'($urandom_range(0, 2)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly valid tracks and rows 0..5, some wild tracks and top rows.
  task automatic run_random(input int count);
    logic [7:0] trk, btn;
    logic [6:0] kv;
    repeat (count) begin
      trk = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, TRACKS - 1));
      btn = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 119));
      case ($urandom_range(0, 7))
        0:       kv = 7'd127;
        1:       kv = 7'd0;
        default: kv = 7'($urandom);
      endcase
      send_press(trk, btn, kv, 4'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd127;
      default: return 8'($urandom_range(24, 72));
    endcase
  endfunction

  initial begin : stimulus
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sbng_pkg::REG_BASE_NOTE;
    cfg_data  <= '0;
    idle_on   <= 1'b1;
    hold_reqs <= 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: every row kind, velocity saturation, dropped tracks.
    send_press(8'd0,   8'd0,   7'd127, 4'd0);   // counter-bass, 127*110% clips
    send_press(8'd1,   8'd20,  7'd100, 4'd5);   // bass row with octave copies
    send_press(8'd2,   8'd40,  7'd64,  4'd9);   // major
    send_press(8'd3,   8'd61,  7'd80,  4'd10);  // minor
    send_press(8'd4,   8'd85,  7'd90,  4'd6);   // dominant seventh
    send_press(8'd5,   8'd100, 7'd33,  4'd3);   // diminished seventh
    send_press(8'd15,  8'd119, 7'd1,   4'd15);  // top valid track, column 19
    send_press(8'd6,   8'd120, 7'd127, 4'd12);  // row six plays as bass
    send_press(8'd7,   8'd255, 7'd50,  4'd1);   // highest button
    send_press(8'd16,  8'd40,  7'd64,  4'd2);   // track out of range
    send_press(8'd255, 8'd0,   7'd127, 4'd15);  // track out of range
    send_press(8'd8,   8'd33,  7'd0,   4'd4);   // zero velocity

    // Top of range: notes above 127 vanish, presses with nothing left go silent;
    // density 3 saturates to dense, 255% saturates to 150%.
    settle();
    program_regs(8'd127, 8'd1, 8'd3, 8'd255, 8'd0);
    send_press(8'd0,  8'd0,   7'd127, 4'd2);
    send_press(8'd1,  8'd20,  7'd90,  4'd7);
    send_press(8'd2,  8'd40,  7'd100, 4'd8);
    send_press(8'd3,  8'd125, 7'd100, 4'd8);    // root 11: no note left
    send_press(8'd4,  8'd80,  7'd100, 4'd11);
    send_press(8'd9,  8'd1,   7'd60,  4'd13);

    // Bottom of range: notes below an octave get no copy; sparse voicing.
    settle();
    program_regs(8'd0, 8'd1, 8'd0, 8'd0, 8'd150);
    send_press(8'd0,  8'd20, 7'd127, 4'd14);
    send_press(8'd10, 8'd80, 7'd127, 4'd0);
    send_press(8'd11, 8'd100, 7'd85, 4'd3);
    send_press(8'd12, 8'd7,  7'd99,  4'd9);

    // Random phases, each under its own register set.
    settle();
    program_regs(8'd36, 8'd0, 8'd1, 8'd100, 8'd100);
    run_random(55);
    for (int p = 0; p < 4; p++) begin
      settle();
      program_regs(pick_base(), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_random(55);
      // Long sink hold-off while presses keep coming: queue fills, input stalls.
      if (p == 1) begin
        hold_reqs <= hold_reqs + 1;
        run_random(25);
      end
    end

    // Last stretch at full rate, no gaps or stalls.
    settle();
    program_regs(8'd48, 8'd1, 8'd2, 8'd150, 8'd150);
    idle_on <= 1'b0;
    run_random(60);

    settle();
    if (errors == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end : stimulus

endmodule
